>>> hdl/blc_pkg.sv
// blc_pkg: shared types and constants for the bounded list engine.
// No dependencies; imported by blc_cell and bounded_list_engine.
`timescale 1ns / 1ps
`default_nettype none

package blc_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // index/count arithmetic width: covers DEPTH up to 511 and the 5-bit position port
    localparam int IDX_W = 9;

    localparam logic [4:0] CAP_RESET = 5'd16;

    typedef enum logic [3:0] {
        OP_PUSH     = 4'd0,
        OP_POP      = 4'd1,
        OP_PEEK     = 4'd2,
        OP_INSERT   = 4'd3,
        OP_REMOVE   = 4'd4,
        OP_READ     = 4'd5,
        OP_WRITE    = 4'd6,
        OP_FILL     = 4'd7,
        OP_FILL_CAP = 4'd8,
        OP_CLEAR    = 4'd9
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    // what every cell does this cycle; each cell compares its own index
    typedef enum logic [2:0] {
        CA_HOLD       = 3'd0,
        CA_WRITE_AT   = 3'd1,
        CA_SHIFT_UP   = 3'd2,
        CA_SHIFT_DOWN = 3'd3,
        CA_FILL_BELOW = 3'd4
    } cell_act_t;

    typedef struct packed {
        cell_act_t          act;
        logic [IDX_W-1:0]   pos;
        logic [IDX_W-1:0]   limit;
    } cell_cmd_t;

endpackage

`default_nettype wire

>>> hdl/bounded_list_engine.sv
// bounded_list_engine: ordered list of up to DEPTH entries held in a row of cells.
// Result: strobed on done in the cycle after start is taken.
// Throughput: one item per cycle; every request, shifts and fills included,
// completes across the whole cell row at once. busy never rises.
// Reset: count cleared, capacity 16, no result pending; entries undefined.
// Results cannot be stalled by the receiver.
`timescale 1ns / 1ps
`default_nettype none

module bounded_list_engine
    import blc_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [3:0]  operation,
    input  wire logic [4:0]  position,
    input  wire logic [31:0] value,
    output logic             done,
    output logic [1:0]       status,
    output logic [31:0]      data_out,
    output logic [4:0]       count_out,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [4:0]  cfg_data
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);
    localparam logic [IDX_W-1:0] DEPTH_X = IDX_W'(DEPTH);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [4:0]    cap_reg;
    logic          done_reg;
    logic [1:0]    status_reg;
    logic [31:0]   data_reg;
    logic [4:0]    count_out_reg;

    logic                  go;
    logic [IDX_W-1:0]      cnt_x;
    logic [IDX_W-1:0]      pos_x;
    logic [IDX_W-1:0]      cap_raw;
    logic [IDX_W-1:0]      cap_x;
    logic [IDX_W-1:0]      cnt_new;
    logic [IDX_W-1:0]      rd_idx;
    logic                  rd_en;
    status_t               st;
    cell_cmd_t             cmd;
    logic [DATA_WIDTH-1:0] word;
    logic [DATA_WIDTH-1:0] rd_word;
    logic [63:0]           rd_ext;

    logic [DATA_WIDTH-1:0] cell_data [DEPTH];

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign go        = start && !busy;

    assign word    = DATA_WIDTH'(value);
    assign cnt_x   = IDX_W'(count_reg);
    assign pos_x   = IDX_W'(position);
    assign cap_raw = IDX_W'(cap_reg);
    assign cap_x   = (cap_raw > DEPTH_X) ? DEPTH_X : cap_raw;

    always_comb
    begin
        cmd.act   = CA_HOLD;
        cmd.pos   = pos_x;
        cmd.limit = cnt_x;
        st        = ST_OK;
        rd_en     = 1'b0;
        rd_idx    = pos_x;
        cnt_new   = cnt_x;
        if (go)
        begin
            unique case (op_t'(operation))
                OP_PUSH:
                begin
                    if (cnt_x >= cap_x)
                        st = ST_FULL;
                    else
                    begin
                        cmd.act = CA_WRITE_AT;
                        cmd.pos = cnt_x;
                        cnt_new = cnt_x + IDX_W'(1);
                    end
                end
                OP_POP:
                begin
                    if (cnt_x == '0)
                        st = ST_EMPTY;
                    else
                    begin
                        rd_en   = 1'b1;
                        rd_idx  = cnt_x - IDX_W'(1);
                        cnt_new = cnt_x - IDX_W'(1);
                    end
                end
                OP_PEEK:
                begin
                    if (cnt_x == '0)
                        st = ST_EMPTY;
                    else
                    begin
                        rd_en  = 1'b1;
                        rd_idx = cnt_x - IDX_W'(1);
                    end
                end
                OP_INSERT:
                begin
                    // full is checked before the position
                    if (cnt_x >= cap_x)
                        st = ST_FULL;
                    else if (pos_x > cnt_x)
                        st = ST_RANGE;
                    else
                    begin
                        cmd.act = CA_SHIFT_UP;
                        cnt_new = cnt_x + IDX_W'(1);
                    end
                end
                OP_REMOVE:
                begin
                    if (cnt_x == '0)
                        st = ST_EMPTY;
                    else if (pos_x >= cnt_x)
                        st = ST_RANGE;
                    else
                    begin
                        rd_en   = 1'b1;
                        cmd.act = CA_SHIFT_DOWN;
                        cnt_new = cnt_x - IDX_W'(1);
                    end
                end
                OP_READ:
                begin
                    if (pos_x >= cnt_x)
                        st = ST_RANGE;
                    else
                        rd_en = 1'b1;
                end
                OP_WRITE:
                begin
                    if (pos_x >= cnt_x)
                        st = ST_RANGE;
                    else
                        cmd.act = CA_WRITE_AT;
                end
                OP_FILL:
                begin
                    cmd.act = CA_FILL_BELOW;
                end
                OP_FILL_CAP:
                begin
                    cmd.act   = CA_FILL_BELOW;
                    cmd.limit = cap_x;
                    cnt_new   = cap_x;
                end
                OP_CLEAR:
                begin
                    cnt_new = '0;
                end
                default:
                begin
                    st = ST_OK;
                end
            endcase
        end
    end

    assign count_next = CW'(cnt_new);

    // the list as a chain: each cell sees its lower and upper neighbor
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] lower;
        logic [DATA_WIDTH-1:0] upper;

        if (i == 0)
        begin : g_first
            assign lower = '0;
        end
        else
        begin : g_lower
            assign lower = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign upper = '0;
        end
        else
        begin : g_upper
            assign upper = cell_data[i+1];
        end

        blc_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .IDX        (i)
        ) u_cell (
            .clk      (clk),
            .cmd      (cmd),
            .word_in  (word),
            .lower_in (lower),
            .upper_in (upper),
            .entry    (cell_data[i])
        );
    end

    // rd_idx is below the count whenever rd_en is set
    assign rd_word = cell_data[rd_idx[AW-1:0]];
    assign rd_ext  = rd_en ? 64'(rd_word) : 64'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            cap_reg   <= CAP_RESET;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= go;
            if (go)
                count_reg <= count_next;
            if (cfg_valid && cfg_ready)
                cap_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            status_reg    <= st;
            data_reg      <= rd_ext[31:0];
            count_out_reg <= 5'(cnt_new);
        end
    end

    assign done      = done_reg;
    assign status    = status_reg;
    assign data_out  = data_reg;
    assign count_out = count_out_reg;

endmodule

`default_nettype wire

>>> hdl/blc_cell.sv
// blc_cell: one list entry. Loads the broadcast word or takes a neighbor's
// entry, decided by its own index against the broadcast command. Uses blc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module blc_cell
    import blc_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int IDX        = 0
)
(
    input  wire logic                  clk,
    input  wire cell_cmd_t             cmd,
    input  wire logic [DATA_WIDTH-1:0] word_in,
    input  wire logic [DATA_WIDTH-1:0] lower_in,
    input  wire logic [DATA_WIDTH-1:0] upper_in,
    output logic      [DATA_WIDTH-1:0] entry
);

    localparam logic [IDX_W-1:0] HERE = IDX_W'(IDX);

    logic [DATA_WIDTH-1:0] entry_reg;
    logic [DATA_WIDTH-1:0] entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        unique case (cmd.act)
            CA_HOLD:
            begin
                entry_next = entry_reg;
            end
            CA_WRITE_AT:
            begin
                if (HERE == cmd.pos)
                    entry_next = word_in;
            end
            CA_SHIFT_UP:
            begin
                if (HERE == cmd.pos)
                    entry_next = word_in;
                else if ((HERE > cmd.pos) && (HERE <= cmd.limit))
                    entry_next = lower_in;
            end
            CA_SHIFT_DOWN:
            begin
                if ((HERE >= cmd.pos) && ((HERE + IDX_W'(1)) < cmd.limit))
                    entry_next = upper_in;
            end
            CA_FILL_BELOW:
            begin
                if (HERE < cmd.limit)
                    entry_next = word_in;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire
